// ----- src/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

  localparam int OP_W   = 3;
  localparam int CTX_W  = 64;
  localparam int PRIO_W = 4;
  localparam int SLP_W  = 32;
  localparam int TASK_W = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 32;
  localparam int SLICE_W = 5;
  localparam int BASE_W = 4;
  localparam int CAP_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OP_W-1:0] OP_YIELD  = 3'd2;
  localparam logic [OP_W-1:0] OP_SLEEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
  localparam logic [OP_W-1:0] OP_STATS  = 3'd5;

  localparam logic [STAT_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STS_IGNORED = 2'd2;

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_BLOCK = 3'd3;
  localparam logic [2:0] ST_STOP  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SLICE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_CAP = 1'b1;

  localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;
  localparam logic [CAP_W-1:0]  CAP_RESET  = 3'd5;
  localparam logic [CNT_W-1:0]  CNT_SAT    = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CTX_W-1:0]  context_req;
    logic [PRIO_W-1:0] priority_req;
    logic [SLP_W-1:0]  sleep_ticks;
    logic [TASK_W-1:0] task_req;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TASK_W-1:0] running_task;
    logic [CTX_W-1:0]  resume_context;
    logic [TASK_W-1:0] new_task;
    logic [CNT_W-1:0]  run_count;
    logic [CNT_W-1:0]  wait_count;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_t;

endpackage

// ----- src/rrts_if.sv -----
// Valid/ready channel interfaces for requests, responses and configuration.
interface rrts_req_if;
  import rrts_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrts_rsp_if;
  import rrts_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrts_cfg_if;
  import rrts_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/round_robin_task_scheduler_top.sv -----
// Round-robin time-slice task scheduler: slot table, per-slot sweep sequencer.
// A non-tick event passes through the response and output states after accept.
// A tick first sweeps every used slot for wake-up and accounting, then decides;
// when the slice is spent, the task is not running or slot 0 runs, it walks the
// ring to the first ready slot, stopping after at most one lap.
// One event at a time; the next can enter in the cycle after the response is taken.
// Reset (synchronous, rst_n low): slot 0 running with base slice, others empty.
module round_robin_task_scheduler_top #(
  parameter int SLOTS = 16
) (
  input logic clk,
  input logic rst_n,
  rrts_req_if.sink   in_ch,
  rrts_rsp_if.source out_ch,
  rrts_cfg_if.sink   cfg_ch
);
  import rrts_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int UW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]         st_r [SLOTS];
  logic [SW-1:0]      nxt_r [SLOTS];
  logic [CTX_W-1:0]   ctx_r [SLOTS];
  logic [63:0]        wake_r [SLOTS];
  logic [SLICE_W-1:0] slc_r [SLOTS];
  logic [SLICE_W-1:0] left_r [SLOTS];
  logic [CNT_W-1:0]   run_r [SLOTS];
  logic [CNT_W-1:0]   wait_r [SLOTS];
  logic [SW-1:0]      cur_r;
  logic [63:0]        tick_r;
  logic [UW-1:0]      used_r;
  logic [BASE_W-1:0]  base_r;
  logic [CAP_W-1:0]   cap_r;
  logic [2:0]         fsm_r;
  logic [SW-1:0]      idx_r;
  logic [SW-1:0]      cand_r;
  logic [UW-1:0]      cnt_r;
  req_t               req_r;
  rsp_t               rsp_r;

  logic [SW-1:0]      cand_nxt;
  logic [SW-1:0]      rq;
  logic [PRIO_W-1:0]  prio_c;
  logic [63:0]        tick_inc;
  logic [SLP_W-1:0]   slp;

  assign in_ch.ready  = (fsm_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (fsm_r == S_OUT);
  assign out_ch.data  = rsp_r;

  assign cand_nxt = nxt_r[cand_r];
  assign rq       = req_r.task_req[SW-1:0];
  assign tick_inc = tick_r + 64'd1;
  assign slp      = (req_r.sleep_ticks == '0) ? SLP_W'(1) : req_r.sleep_ticks;
  assign prio_c   = (req_r.priority_req > PRIO_W'(cap_r)) ? PRIO_W'(cap_r)
                                                          : req_r.priority_req;

  // Task slot numbers at or beyond the used count or the table are out of range
  function automatic logic req_in_range(input logic [TASK_W-1:0] t,
                                        input logic [UW-1:0] used);
    return (32'(t) < 32'(used)) && (32'(t) < SLOTS);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i]   <= ST_EMPTY;
        nxt_r[i]  <= '0;
        ctx_r[i]  <= '0;
        wake_r[i] <= '0;
        slc_r[i]  <= '0;
        left_r[i] <= '0;
        run_r[i]  <= '0;
        wait_r[i] <= '0;
      end
      st_r[0]   <= ST_RUN;
      slc_r[0]  <= SLICE_W'(BASE_RESET);
      left_r[0] <= SLICE_W'(BASE_RESET);
      cur_r  <= '0;
      tick_r <= '0;
      used_r <= UW'(1);
      base_r <= BASE_RESET;
      cap_r  <= CAP_RESET;
      fsm_r  <= S_IDLE;
      idx_r  <= '0;
      cand_r <= '0;
      cnt_r  <= '0;
    end else begin
      // Register writes
      if (cfg_ch.valid) begin
        if (cfg_ch.data.index == REG_BASE_SLICE) base_r <= cfg_ch.data.data;
        else cap_r <= cfg_ch.data.data[CAP_W-1:0];
      end
      unique case (fsm_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r <= in_ch.data;
            rsp_r <= '0;
            idx_r <= '0;
            if (in_ch.data.op == OP_TICK) begin
              ctx_r[cur_r] <= in_ch.data.context_req;
              tick_r <= tick_inc;
              fsm_r <= S_SWEEP;
            end else begin
              fsm_r <= S_RESP;
            end
          end
        end
        // Wake and account one slot per cycle
        S_SWEEP: begin
          if (st_r[idx_r] == ST_BLOCK && wake_r[idx_r] != '0 &&
              wake_r[idx_r] <= tick_r) begin
            st_r[idx_r]   <= ST_READY;
            wake_r[idx_r] <= '0;
            if (wait_r[idx_r] != CNT_SAT) wait_r[idx_r] <= wait_r[idx_r] + 1'b1;
          end else if (idx_r == cur_r && st_r[idx_r] == ST_RUN) begin
            if (run_r[idx_r] != CNT_SAT) run_r[idx_r] <= run_r[idx_r] + 1'b1;
          end else if (st_r[idx_r] == ST_READY) begin
            if (wait_r[idx_r] != CNT_SAT) wait_r[idx_r] <= wait_r[idx_r] + 1'b1;
          end
          if (UW'(idx_r) + UW'(1) >= used_r) fsm_r <= S_DEC;
          else idx_r <= idx_r + 1'b1;
        end
        // Spend slice, decide on reschedule
        S_DEC: begin
          cand_r <= cur_r;
          cnt_r  <= '0;
          if (st_r[cur_r] != ST_RUN || cur_r == '0) begin
            fsm_r <= S_SRCH;
          end else begin
            if (left_r[cur_r] > 1) begin
              left_r[cur_r] <= left_r[cur_r] - 1'b1;
              fsm_r <= S_RESP;
            end else begin
              left_r[cur_r] <= '0;
              fsm_r <= S_SRCH;
            end
          end
        end
        // Walk the ring one step per cycle
        S_SRCH: begin
          cand_r <= cand_nxt;
          cnt_r  <= cnt_r + 1'b1;
          if (st_r[cand_nxt] == ST_READY) begin
            if (st_r[cur_r] == ST_RUN) st_r[cur_r] <= ST_READY;
            st_r[cand_nxt]   <= ST_RUN;
            left_r[cand_nxt] <= slc_r[cand_nxt];
            cur_r <= cand_nxt;
            fsm_r <= S_RESP;
          end else if (cand_nxt == cur_r || 32'(cnt_r) >= SLOTS) begin
            if (st_r[cur_r] != ST_RUN) begin
              cur_r     <= '0;
              st_r[0]   <= ST_RUN;
              left_r[0] <= slc_r[0];
            end
            fsm_r <= S_RESP;
          end
        end
        // Apply non-tick events, build the response
        S_RESP: begin
          fsm_r <= S_OUT;
          rsp_r.running_task   <= TASK_W'(cur_r);
          rsp_r.resume_context <= ctx_r[cur_r];
          unique case (req_r.op)
            OP_TICK: begin
            end
            OP_CREATE: begin
              if (32'(used_r) >= SLOTS) begin
                rsp_r.status <= STS_FULL;
              end else begin
                used_r <= used_r + 1'b1;
                st_r[used_r[SW-1:0]]   <= ST_READY;
                ctx_r[used_r[SW-1:0]]  <= req_r.context_req;
                wake_r[used_r[SW-1:0]] <= '0;
                slc_r[used_r[SW-1:0]]  <= SLICE_W'(base_r) + SLICE_W'(prio_c);
                left_r[used_r[SW-1:0]] <= SLICE_W'(base_r) + SLICE_W'(prio_c);
                run_r[used_r[SW-1:0]]  <= '0;
                wait_r[used_r[SW-1:0]] <= '0;
                nxt_r[used_r[SW-1:0]]  <= nxt_r[cur_r];
                nxt_r[cur_r] <= used_r[SW-1:0];
                rsp_r.new_task <= TASK_W'(used_r);
              end
            end
            OP_YIELD: left_r[cur_r] <= '0;
            OP_SLEEP: begin
              if (cur_r == '0) begin
                rsp_r.status <= STS_IGNORED;
              end else begin
                wake_r[cur_r] <= tick_r + 64'(slp);
                st_r[cur_r]   <= ST_BLOCK;
                left_r[cur_r] <= '0;
              end
            end
            OP_STOP: begin
              if (req_r.task_req == '0 || !req_in_range(req_r.task_req, used_r)) begin
                rsp_r.status <= STS_IGNORED;
              end else begin
                st_r[rq]   <= ST_STOP;
                left_r[rq] <= '0;
              end
            end
            OP_STATS: begin
              if (!req_in_range(req_r.task_req, used_r)) begin
                rsp_r.status <= STS_IGNORED;
              end else begin
                rsp_r.run_count  <= run_r[rq];
                rsp_r.wait_count <= wait_r[rq];
              end
            end
            default: rsp_r.status <= STS_IGNORED;
          endcase
        end
        // Hold the result until taken
        S_OUT: begin
          if (out_ch.ready) fsm_r <= S_IDLE;
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the round-robin task scheduler top level.
module tb_top;
  import rrts_pkg::*;

  localparam int NSLOT     = 16;
  localparam int N_RANDOM  = 1500;
  localparam int N_PHASES  = 4;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_CYC = 60;
  localparam logic [OP_W-1:0] OP_BAD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD7 = 3'd7;

  typedef struct {
    rsp_t pred;
    bit   typed;
    rsp_t lit;
  } sched_exp_t;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t lit;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rrts_req_if in_if();
  rrts_rsp_if out_if();
  rrts_cfg_if cfg_if();

  round_robin_task_scheduler_top #(.SLOTS(NSLOT)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Scheduler shadow state
  logic [BASE_W-1:0]  m_base;
  logic [CAP_W-1:0]   m_cap;
  logic [2:0]         m_state [NSLOT];
  logic [TASK_W-1:0]  m_next  [NSLOT];
  logic [CTX_W-1:0]   m_ctx   [NSLOT];
  logic [63:0]        m_wake  [NSLOT];
  logic [SLICE_W-1:0] m_slice [NSLOT];
  logic [SLICE_W-1:0] m_left  [NSLOT];
  logic [CNT_W-1:0]   m_run   [NSLOT];
  logic [CNT_W-1:0]   m_wait  [NSLOT];
  logic [TASK_W-1:0]  m_cur;
  logic [63:0]        m_ticks;
  int                 m_used;

  sched_exp_t pending_rsp[$];
  bit   typed_q[$];
  rsp_t lit_q[$];
  int   mismatches;
  int   burst_left;
  bit   hold_req;
  int   hold_cnt;
  int   pat_left;
  int   pat_mode;

  // Clock and reset
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    forever #5 clk = ~clk;
  end

  // Time limit
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void sched_reset();
    m_base = BASE_RESET;
    m_cap = CAP_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      m_state[i] = ST_EMPTY;
      m_next[i] = '0;
      m_ctx[i] = '0;
      m_wake[i] = '0;
      m_slice[i] = '0;
      m_left[i] = '0;
      m_run[i] = '0;
      m_wait[i] = '0;
    end
    m_state[0] = ST_RUN;
    m_slice[0] = SLICE_W'(BASE_RESET);
    m_left[0] = SLICE_W'(BASE_RESET);
    m_cur = '0;
    m_ticks = '0;
    m_used = 1;
  endfunction

  // Walk the ring for the next ready slot; fall back to slot 0 if the current task is not running
  function automatic void sched_pick();
    logic [TASK_W-1:0] cur;
    logic [TASK_W-1:0] cand;
    cur = m_cur;
    cand = cur;
    for (int n = 0; n <= NSLOT; n++) begin
      cand = m_next[cand];
      if (m_state[cand] == ST_READY) begin
        if (m_state[cur] == ST_RUN) m_state[cur] = ST_READY;
        m_state[cand] = ST_RUN;
        m_left[cand] = m_slice[cand];
        m_cur = cand;
        return;
      end
      if (cand == cur) break;
    end
    if (m_state[cur] != ST_RUN) begin
      m_cur = '0;
      m_state[0] = ST_RUN;
      m_left[0] = m_slice[0];
    end
  endfunction

  // Save context, wake sleepers, account ticks, spend the slice
  function automatic void sched_tick(logic [CTX_W-1:0] ctx);
    int cur;
    cur = m_cur;
    m_ctx[cur] = ctx;
    m_ticks = m_ticks + 64'd1;
    for (int i = 0; i < m_used; i++) begin
      if (m_state[i] == ST_BLOCK && m_wake[i] != 0 && m_wake[i] <= m_ticks) begin
        m_state[i] = ST_READY;
        m_wake[i] = '0;
      end
      if (i == cur && m_state[i] == ST_RUN) begin
        if (m_run[i] != CNT_SAT) m_run[i] = m_run[i] + 1'b1;
      end else if (m_state[i] == ST_READY) begin
        if (m_wait[i] != CNT_SAT) m_wait[i] = m_wait[i] + 1'b1;
      end
    end
    if (m_state[cur] != ST_RUN || cur == 0) begin
      sched_pick();
      return;
    end
    if (m_left[cur] > 0) m_left[cur] = m_left[cur] - 1'b1;
    if (m_left[cur] == 0) sched_pick();
  endfunction

  function automatic rsp_t sched_apply(req_t r);
    rsp_t o;
    int t;
    logic [PRIO_W-1:0] pr;
    logic [63:0] dur;
    o = '0;
    o.status = STS_DONE;
    case (r.op)
      OP_TICK: sched_tick(r.context_req);
      OP_CREATE: begin
        if (m_used >= NSLOT) begin
          o.status = STS_FULL;
        end else begin
          t = m_used;
          m_used++;
          pr = (r.priority_req > m_cap) ? PRIO_W'(m_cap) : r.priority_req;
          m_state[t] = ST_READY;
          m_ctx[t] = r.context_req;
          m_wake[t] = '0;
          m_slice[t] = SLICE_W'(m_base) + SLICE_W'(pr);
          m_left[t] = m_slice[t];
          m_run[t] = '0;
          m_wait[t] = '0;
          m_next[t] = m_next[m_cur];
          m_next[m_cur] = TASK_W'(t);
          o.new_task = TASK_W'(t);
        end
      end
      OP_YIELD: m_left[m_cur] = '0;
      OP_SLEEP: begin
        if (m_cur == 0) begin
          o.status = STS_IGNORED;
        end else begin
          dur = (r.sleep_ticks != 0) ? 64'(r.sleep_ticks) : 64'd1;
          m_wake[m_cur] = m_ticks + dur;
          m_state[m_cur] = ST_BLOCK;
          m_left[m_cur] = '0;
        end
      end
      OP_STOP: begin
        if (r.task_req == 0 || r.task_req >= m_used) begin
          o.status = STS_IGNORED;
        end else begin
          m_state[r.task_req] = ST_STOP;
          m_left[r.task_req] = '0;
        end
      end
      OP_STATS: begin
        if (r.task_req >= m_used) begin
          o.status = STS_IGNORED;
        end else begin
          o.run_count = m_run[r.task_req];
          o.wait_count = m_wait[r.task_req];
        end
      end
      default: o.status = STS_IGNORED;
    endcase
    o.running_task = m_cur;
    o.resume_context = m_ctx[m_cur];
    return o;
  endfunction

  function automatic void report_diff(string tag, rsp_t e, rsp_t a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s mismatch: exp sts=%0d run=%0d ctx=%h new=%0d rc=%0d wc=%0d",
                 tag, e.status, e.running_task, e.resume_context, e.new_task,
                 e.run_count, e.wait_count);
        $display("  act sts=%0d run=%0d ctx=%h new=%0d rc=%0d wc=%0d",
                 a.status, a.running_task, a.resume_context, a.new_task,
                 a.run_count, a.wait_count);
      end
    end
  endfunction

  // Observe transactions: mirror register writes, predict on accept, check on response
  always @(posedge clk) begin
    sched_exp_t e;
    if (!rst_n) begin
      sched_reset();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.index == REG_BASE_SLICE) m_base = cfg_if.data.data;
        else m_cap = cfg_if.data.data[CAP_W-1:0];
      end
      if (in_if.valid && in_if.ready) begin
        e.pred = sched_apply(in_if.data);
        e.typed = typed_q.pop_front();
        e.lit = lit_q.pop_front();
        pending_rsp.push_back(e);
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response with nothing expected");
        end else begin
          e = pending_rsp.pop_front();
          report_diff("predicted", e.pred, out_if.data);
          if (e.typed) report_diff("directed", e.lit, out_if.data);
        end
      end
    end
  end

  // Receiver: random stall patterns plus one long hold-off
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= HOLD_LEN;
      out_if.ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(5, 60);
      end
      pat_left = pat_left - 1;
      case (pat_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ($urandom_range(0, 1) != 0);
        default: out_if.ready <= (pat_left % 4) != 0;
      endcase
    end
  end

  // Offer one transaction, with burst gaps in between
  task automatic send_item(req_t r, bit typed, rsp_t lit);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    typed_q.push_back(typed);
    lit_q.push_back(lit);
    in_if.valid <= 1'b1;
    in_if.data <= r;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    burst_left--;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: val};
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
  endtask

  // Drain outstanding responses before touching registers
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_t mk_req(logic [OP_W-1:0] op, logic [CTX_W-1:0] ctx,
                                  logic [PRIO_W-1:0] pr, logic [SLP_W-1:0] sl,
                                  logic [TASK_W-1:0] tk);
    req_t r;
    r.op = op;
    r.context_req = ctx;
    r.priority_req = pr;
    r.sleep_ticks = sl;
    r.task_req = tk;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic [STAT_W-1:0] st, logic [TASK_W-1:0] rt,
                                  logic [CTX_W-1:0] ctx, logic [TASK_W-1:0] nt,
                                  logic [CNT_W-1:0] rc, logic [CNT_W-1:0] wc);
    rsp_t o;
    o.status = st;
    o.running_task = rt;
    o.resume_context = ctx;
    o.new_task = nt;
    o.run_count = rc;
    o.wait_count = wc;
    return o;
  endfunction

  // Mostly scheduling traffic, rare creates so slots last across phases
  function automatic req_t rand_req();
    req_t r;
    int pick;
    logic [OP_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_TICK;
    else if (pick < 48) op = OP_CREATE;
    else if (pick < 60) op = OP_YIELD;
    else if (pick < 72) op = OP_SLEEP;
    else if (pick < 80) op = OP_STOP;
    else if (pick < 98) op = OP_STATS;
    else op = ($urandom_range(0, 1) != 0) ? OP_BAD6 : OP_BAD7;
    r.op = op;
    r.context_req = {$urandom, $urandom};
    r.priority_req = PRIO_W'($urandom_range(0, 15));
    r.sleep_ticks = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 20);
    r.task_req = TASK_W'($urandom_range(0, 15));
    return r;
  endfunction

  // Stimulus
  initial begin
    stim_row_t rows[$];
    rsp_t none;
    logic [CFG_DAT_W-1:0] base_set [N_PHASES];
    logic [CFG_DAT_W-1:0] cap_set  [N_PHASES];
    none = '0;
    mismatches = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_cnt = 0;
    pat_left = 0;
    pat_mode = 0;
    base_set = '{4'd1, 4'd15, 4'd3, 4'd2};
    cap_set  = '{4'd0, 4'd7, 4'd2, 4'd5};

    // Directed rows; literal answers where the reset state makes them obvious
    rows.push_back('{mk_req(OP_STATS, '0, '0, '0, 4'd0), 1,
                     mk_rsp(STS_DONE, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_STOP, '0, '0, '0, 4'd0), 1,
                     mk_rsp(STS_IGNORED, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_SLEEP, '0, '0, '1, 4'd0), 1,
                     mk_rsp(STS_IGNORED, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_STATS, '0, '0, '0, 4'd15), 1,
                     mk_rsp(STS_IGNORED, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_STOP, '0, '0, '0, 4'd15), 1,
                     mk_rsp(STS_IGNORED, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_BAD6, '1, '1, '1, 4'd15), 1,
                     mk_rsp(STS_IGNORED, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_BAD7, '1, '1, '1, 4'd15), 1,
                     mk_rsp(STS_IGNORED, 4'd0, '0, '0, '0, '0)});
    rows.push_back('{mk_req(OP_TICK, '1, '0, '0, '0), 1,
                     mk_rsp(STS_DONE, 4'd0, '1, '0, '0, '0)});
    rows.push_back('{mk_req(OP_CREATE, 64'h0123_4567_89ab_cdef, 4'd15, '0, '0), 1,
                     mk_rsp(STS_DONE, 4'd0, '1, 4'd1, '0, '0)});
    rows.push_back('{mk_req(OP_TICK, '0, '0, '0, '0), 1,
                     mk_rsp(STS_DONE, 4'd1, 64'h0123_4567_89ab_cdef, '0, '0, '0)});
    rows.push_back('{mk_req(OP_CREATE, 64'hfedc_ba98_7654_3210, 4'd0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_YIELD, '0, '0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_TICK, 64'h5555_aaaa_5555_aaaa, '0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_SLEEP, '0, '0, 32'd0, '0), 0, none});
    rows.push_back('{mk_req(OP_TICK, 64'haaaa_5555_aaaa_5555, '0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_TICK, 64'h1, '0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_SLEEP, '0, '0, '1, '0), 0, none});
    rows.push_back('{mk_req(OP_TICK, 64'h2, '0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_STATS, '0, '0, '0, 4'd1), 0, none});
    rows.push_back('{mk_req(OP_STOP, '0, '0, '0, 4'd2), 0, none});
    rows.push_back('{mk_req(OP_TICK, 64'h3, '0, '0, '0), 0, none});
    rows.push_back('{mk_req(OP_STATS, '0, '0, '0, 4'd2), 0, none});
    rows.push_back('{mk_req(OP_TICK, 64'h4, '0, '0, '0), 0, none});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].lit);

    // Random phases, each under a new register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_BASE_SLICE, base_set[ph]);
      write_reg(REG_PRIORITY_CAP, cap_set[ph]);
      for (int k = 0; k < N_RANDOM / N_PHASES; k++) begin
        if (ph == 1 && k == 20) hold_req = 1'b1;
        send_item(rand_req(), 1'b0, none);
      end
    end

    // Create once per slot so the table fills and the later creates report it full, then one tick
    for (int k = 0; k < NSLOT; k++)
      send_item(mk_req(OP_CREATE, {$urandom, $urandom}, PRIO_W'($urandom_range(0, 15)),
                       '0, '0),
                1'b0, none);
    send_item(mk_req(OP_TICK, {$urandom, $urandom}, '0, '0, '0), 1'b0, none);

    in_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rrts_pkg.sv
src/rrts_if.sv
src/round_robin_task_scheduler_top.sv
verif/tb_top.sv
